[rtl/xdc_pkg.sv]
// Shared types, constants and helpers for the XPBD distance constraint block.
package xdc_pkg;

  // Field widths.
  localparam int PosW    = 32;
  localparam int InvW    = 24;
  localparam int RestW   = 31;
  localparam int LamW    = 32;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 1;

  // Pipeline geometry.
  localparam int SqrtLat = 32;   // one root bit per stage
  localparam int DivLat  = 64;   // one quotient bit per stage
  localparam int DivW    = 64;
  localparam int DenW    = 33;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] ComplianceReset = 32'd0;
  localparam logic [CfgW-1:0] SubstepDtReset  = 32'd1092;

  // Cap on one axis correction (2^34 units).
  localparam logic [34:0] CorrCap = 35'h4_0000_0000;
  // Cap on the multiplier step (2^33 units).
  localparam logic [33:0] StepCap = 34'h2_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMPLIANCE = 1'b0,
    REG_SUBSTEP_DT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_APPLIED     = 2'd0,
    ST_BOTH_PINNED = 2'd1,
    ST_ZERO_DIST   = 2'd2,
    ST_ZERO_WEIGHT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALPHA_IDLE,
    ALPHA_SQUARE,
    ALPHA_CHECK,
    ALPHA_DIV
  } alpha_state_e;

  // One constraint as it travels down the pipeline.
  typedef struct packed {
    logic [2:0][PosW-1:0] pos_a;
    logic [2:0][PosW-1:0] pos_b;
    logic [InvW-1:0]      inv_a;
    logic [InvW-1:0]      inv_b;
    logic                 pin_a;
    logic                 pin_b;
    logic [RestW-1:0]     rest;
    logic [LamW-1:0]      lam;
    status_e              status;
    logic                 sh;
    logic [2:0]           dneg;
    logic [2:0][31:0]     dm;
    logic [47:0]          al_mag;
    logic                 dl_neg;
  } item_t;

  // Saturate a signed sum to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/xdc_alpha.sv]
// Configuration registers and the iterative unit that derives alpha from them.
module xdc_alpha (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [xdc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [xdc_pkg::CfgW-1:0]    cfg_data_i,
  output logic                        busy_o,
  output logic [31:0]                 alpha_o
);
  import xdc_pkg::*;

  alpha_state_e state_q, state_d;
  logic [31:0] compliance_q, compliance_d;
  logic [31:0] dt_q, dt_d;
  logic [31:0] alpha_q, alpha_d;
  logic [63:0] dt2_q, dt2_d;
  logic [64:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [47:0] num_scaled;
  logic [64:0] rem_shift;
  logic [31:0] quo_next;

  assign num_scaled = {compliance_q, 16'h0000};
  assign rem_shift  = {rem_q[63:0], 1'b0};

  // Next state: any register write restarts the computation.
  always_comb begin
    state_d = state_q;
    if (cfg_valid_i) begin
      state_d = ALPHA_SQUARE;
    end else begin
      case (state_q)
        ALPHA_IDLE:   state_d = ALPHA_IDLE;
        ALPHA_SQUARE: state_d = ALPHA_CHECK;
        ALPHA_CHECK: begin
          if ({16'h0000, num_scaled} >= dt2_q) state_d = ALPHA_IDLE;
          else state_d = ALPHA_DIV;
        end
        ALPHA_DIV: begin
          if (cnt_q == 5'd31) state_d = ALPHA_IDLE;
        end
        default: state_d = ALPHA_IDLE;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    busy_o  = (state_q != ALPHA_IDLE);
    alpha_o = alpha_q;
  end

  // Register writes and the restoring division compliance * 2^48 / dt^2.
  always_comb begin
    compliance_d = compliance_q;
    dt_d         = dt_q;
    alpha_d      = alpha_q;
    dt2_d        = dt2_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    quo_next     = {quo_q[30:0], 1'b0};
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COMPLIANCE: compliance_d = cfg_data_i;
        REG_SUBSTEP_DT: dt_d = cfg_data_i;
        default: ;
      endcase
    end else begin
      case (state_q)
        ALPHA_SQUARE: dt2_d = dt_q * dt_q;
        ALPHA_CHECK: begin
          if ({16'h0000, num_scaled} >= dt2_q) begin
            alpha_d = 32'hFFFF_FFFF;
          end else begin
            rem_d = {17'h0_0000, num_scaled};
            quo_d = 32'h0;
            cnt_d = 5'd0;
          end
        end
        ALPHA_DIV: begin
          if (rem_shift >= {1'b0, dt2_q}) begin
            rem_d    = rem_shift - {1'b0, dt2_q};
            quo_next = {quo_q[30:0], 1'b1};
          end else begin
            rem_d = rem_shift;
          end
          quo_d = quo_next;
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd31) alpha_d = quo_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ALPHA_IDLE;
      compliance_q <= ComplianceReset;
      dt_q         <= SubstepDtReset;
      alpha_q      <= 32'h0;
      cnt_q        <= 5'd0;
    end else begin
      state_q      <= state_d;
      compliance_q <= compliance_d;
      dt_q         <= dt_d;
      alpha_q      <= alpha_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt2_q <= dt2_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule

[rtl/xdc_sqrt.sv]
// Pipelined floor square root of a 64-bit value, one root bit per stage.
module xdc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] radicand_i,
  output logic        valid_o,
  output logic [31:0] root_o
);
  import xdc_pkg::*;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sqrt_stage_t;

  sqrt_stage_t st_in [SqrtLat];
  sqrt_stage_t st_d  [SqrtLat];
  sqrt_stage_t st_q  [SqrtLat];
  logic [SqrtLat-1:0] v_q;

  for (genvar k = 0; k < SqrtLat; k++) begin : g_stage
    logic [35:0] cur;
    logic [35:0] trial;

    if (k == 0) begin : g_first
      assign st_in[k] = '{rem: '0, root: '0, rad: radicand_i};
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[k] <= 1'b0;
        else v_q[k] <= valid_i;
      end
    end else begin : g_next
      assign st_in[k] = st_q[k-1];
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[k] <= 1'b0;
        else v_q[k] <= v_q[k-1];
      end
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      cur   = {st_in[k].rem, st_in[k].rad[63:62]};
      trial = {2'b00, st_in[k].root, 2'b01};
      st_d[k].rad = {st_in[k].rad[61:0], 2'b00};
      if (cur >= trial) begin
        st_d[k].rem  = 34'(cur - trial);
        st_d[k].root = {st_in[k].root[30:0], 1'b1};
      end else begin
        st_d[k].rem  = cur[33:0];
        st_d[k].root = {st_in[k].root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= st_d[k];
    end
  end

  assign valid_o = v_q[SqrtLat-1];
  assign root_o  = st_q[SqrtLat-1].root;

endmodule

[rtl/xdc_div.sv]
// Pipelined unsigned restoring divider, 64-bit dividend, one quotient bit per stage.
module xdc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [xdc_pkg::DivW-1:0] num_i,
  input  logic [xdc_pkg::DenW-1:0] den_i,
  output logic                     valid_o,
  output logic [xdc_pkg::DivW-1:0] quot_o
);
  import xdc_pkg::*;

  // The low bits of nq fill with quotient as the dividend shifts out on top.
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [DivW-1:0] nq;
    logic [DenW-1:0] den;
  } div_stage_t;

  div_stage_t st_in [DivLat];
  div_stage_t st_d  [DivLat];
  div_stage_t st_q  [DivLat];
  logic [DivLat-1:0] v_q;

  for (genvar k = 0; k < DivLat; k++) begin : g_stage
    logic [DenW:0] cur;

    if (k == 0) begin : g_first
      assign st_in[k] = '{rem: '0, nq: num_i, den: den_i};
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[k] <= 1'b0;
        else v_q[k] <= valid_i;
      end
    end else begin : g_next
      assign st_in[k] = st_q[k-1];
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[k] <= 1'b0;
        else v_q[k] <= v_q[k-1];
      end
    end

    // Shift in one dividend bit and subtract the divisor when it fits.
    always_comb begin
      cur = {st_in[k].rem, st_in[k].nq[DivW-1]};
      st_d[k].den = st_in[k].den;
      if (cur >= {1'b0, st_in[k].den}) begin
        st_d[k].rem = DenW'(cur - {1'b0, st_in[k].den});
        st_d[k].nq  = {st_in[k].nq[DivW-2:0], 1'b1};
      end else begin
        st_d[k].rem = cur[DenW-1:0];
        st_d[k].nq  = {st_in[k].nq[DivW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= st_d[k];
    end
  end

  assign valid_o = v_q[DivLat-1];
  assign quot_o  = st_q[DivLat-1].nq;

endmodule

[rtl/xpbd_distance_constraint.sv]
// Top level of the XPBD distance constraint projection pipeline.
// Usage: a constraint word is taken whenever start is high and busy is low, one per
// clock, and its result word appears on the output ports with done_o high for one
// cycle, in order. The pipeline holds the 32-stage square root and the 64-stage
// dividers that compute the multiplier step and the unit direction. The receiver
// cannot stall: results must be taken as they come. A register write restarts the
// alpha unit, which holds busy high through its square, check and divide states
// (square and check only when alpha saturates); cfg_ready_o is always high.
module xpbd_distance_constraint (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [xdc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [xdc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [xdc_pkg::PosW-1:0]    first_x_i,
  input  logic [xdc_pkg::PosW-1:0]    first_y_i,
  input  logic [xdc_pkg::PosW-1:0]    first_z_i,
  input  logic [xdc_pkg::PosW-1:0]    second_x_i,
  input  logic [xdc_pkg::PosW-1:0]    second_y_i,
  input  logic [xdc_pkg::PosW-1:0]    second_z_i,
  input  logic [xdc_pkg::InvW-1:0]    first_inv_mass_i,
  input  logic [xdc_pkg::InvW-1:0]    second_inv_mass_i,
  input  logic                        first_pinned_i,
  input  logic                        second_pinned_i,
  input  logic [xdc_pkg::RestW-1:0]   rest_length_i,
  input  logic [xdc_pkg::LamW-1:0]    lambda_in_i,
  output logic                        done_o,
  output logic [xdc_pkg::PosW-1:0]    new_first_x_o,
  output logic [xdc_pkg::PosW-1:0]    new_first_y_o,
  output logic [xdc_pkg::PosW-1:0]    new_first_z_o,
  output logic [xdc_pkg::PosW-1:0]    new_second_x_o,
  output logic [xdc_pkg::PosW-1:0]    new_second_y_o,
  output logic [xdc_pkg::PosW-1:0]    new_second_z_o,
  output logic [xdc_pkg::LamW-1:0]    lambda_out_o,
  output logic [1:0]                  status_o
);
  import xdc_pkg::*;

  logic [31:0] alpha;
  logic        alpha_busy;

  // Configuration registers and alpha.
  xdc_alpha u_alpha (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (alpha_busy),
    .alpha_o     (alpha)
  );

  assign busy        = alpha_busy;
  assign cfg_ready_o = 1'b1;

  // Stage 0: capture the word.
  item_t s0_d, s0_q;
  logic  s0_v_q;

  always_comb begin
    s0_d        = '0;
    s0_d.pos_a  = {first_z_i, first_y_i, first_x_i};
    s0_d.pos_b  = {second_z_i, second_y_i, second_x_i};
    s0_d.inv_a  = first_inv_mass_i;
    s0_d.inv_b  = second_inv_mass_i;
    s0_d.pin_a  = first_pinned_i;
    s0_d.pin_b  = second_pinned_i;
    s0_d.rest   = rest_length_i;
    s0_d.lam    = lambda_in_i;
  end

  // Stage 1: separation, magnitudes, status, squares and alpha * |lambda|.
  item_t       s1_d, s1_q;
  logic        s1_v_q;
  logic [61:0] s1_sq_d [3];
  logic [61:0] s1_sq_q [3];
  logic signed [32:0] sep [3];
  logic [30:0] half_mag [3];
  logic [31:0] lam_mag;
  logic [63:0] al_prod;

  always_comb begin
    s1_d = s0_q;
    for (int i = 0; i < 3; i++) begin
      sep[i] = $signed({s0_q.pos_a[i][31], s0_q.pos_a[i]})
             - $signed({s0_q.pos_b[i][31], s0_q.pos_b[i]});
      s1_d.dneg[i] = sep[i][32];
      s1_d.dm[i]   = sep[i][32] ? 32'(-sep[i]) : sep[i][31:0];
    end
    s1_d.sh = s1_d.dm[0][31] | s1_d.dm[1][31] | s1_d.dm[2][31];
    for (int i = 0; i < 3; i++) begin
      half_mag[i] = s1_d.sh ? s1_d.dm[i][31:1] : s1_d.dm[i][30:0];
      s1_sq_d[i]  = half_mag[i] * half_mag[i];
    end
    if (s0_q.pin_a && s0_q.pin_b) begin
      s1_d.status = ST_BOTH_PINNED;
    end else if (s0_q.pos_a == s0_q.pos_b) begin
      s1_d.status = ST_ZERO_DIST;
    end else if (s0_q.inv_a == '0 && s0_q.inv_b == '0) begin
      s1_d.status = ST_ZERO_WEIGHT;
    end else begin
      s1_d.status = ST_APPLIED;
    end
    lam_mag     = s0_q.lam[31] ? 32'(-s0_q.lam) : s0_q.lam;
    al_prod     = alpha * lam_mag;
    s1_d.al_mag = al_prod[63:16];
  end

  // Stage 2: sum of squares.
  item_t       s2_q;
  logic        s2_v_q;
  logic [63:0] s2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s0_v_q <= start && !alpha_busy;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !alpha_busy) s0_q <= s0_d;
    s1_q     <= s1_d;
    s1_sq_q  <= s1_sq_d;
    s2_q     <= s1_q;
    s2_sum_q <= 64'(s1_sq_q[0]) + 64'(s1_sq_q[1]) + 64'(s1_sq_q[2]);
  end

  // Square root, with the word riding alongside.
  logic        sqrt_v;
  logic [31:0] sqrt_root;
  item_t       sq_line_q [SqrtLat];

  xdc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s2_v_q),
    .radicand_i (s2_sum_q),
    .valid_o    (sqrt_v),
    .root_o     (sqrt_root)
  );

  always_ff @(posedge clk_i) begin
    sq_line_q[0] <= s2_q;
    for (int k = 1; k < SqrtLat; k++) sq_line_q[k] <= sq_line_q[k-1];
  end

  // Stage 3: distance, error, numerator and denominator of the step, direction numerators.
  item_t              s3_d, s3_q;
  logic               s3_v_q;
  logic [DivW-1:0]    s3_num_d, s3_num_q;
  logic [DenW-1:0]    s3_den_d, s3_den_q;
  logic [DivW-1:0]    s3_gnum_d [3];
  logic [DivW-1:0]    s3_gnum_q [3];
  logic [DenW-1:0]    s3_dist_d, s3_dist_q;
  logic signed [33:0] err;
  logic signed [49:0] al_s;
  logic signed [49:0] step_num;
  logic [49:0]        step_mag;

  always_comb begin
    s3_d      = sq_line_q[SqrtLat-1];
    s3_dist_d = s3_d.sh ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
    err       = $signed({1'b0, s3_dist_d}) - $signed({3'b000, s3_d.rest});
    al_s      = s3_d.lam[31] ? -$signed({2'b00, s3_d.al_mag}) : $signed({2'b00, s3_d.al_mag});
    step_num  = $signed({{16{err[33]}}, err}) + al_s;
    step_mag  = step_num[49] ? 50'(-step_num) : step_num;
    s3_d.dl_neg = !step_num[49] && (step_num != '0);
    s3_num_d  = {step_mag[47:0], 16'h0000};
    s3_den_d  = DenW'(s3_d.inv_a) + DenW'(s3_d.inv_b) + DenW'(alpha);
    for (int i = 0; i < 3; i++) s3_gnum_d[i] = {2'b00, s3_d.dm[i], 30'h0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else s3_v_q <= sqrt_v;
  end

  always_ff @(posedge clk_i) begin
    s3_q      <= s3_d;
    s3_num_q  <= s3_num_d;
    s3_den_q  <= s3_den_d;
    s3_gnum_q <= s3_gnum_d;
    s3_dist_q <= s3_dist_d;
  end

  // Dividers: multiplier step and the three direction components.
  logic [3:0]      div_v;
  logic [DivW-1:0] step_q;
  logic [DivW-1:0] dir_q [3];
  item_t           dv_line_q [DivLat];

  xdc_div u_div_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_v_q),
    .num_i   (s3_num_q),
    .den_i   (s3_den_q),
    .valid_o (div_v[3]),
    .quot_o  (step_q)
  );

  for (genvar i = 0; i < 3; i++) begin : g_dir
    xdc_div u_div_dir (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s3_v_q),
      .num_i   (s3_gnum_q[i]),
      .den_i   (s3_dist_q),
      .valid_o (div_v[i]),
      .quot_o  (dir_q[i])
    );
  end

  always_ff @(posedge clk_i) begin
    dv_line_q[0] <= s3_q;
    for (int k = 1; k < DivLat; k++) dv_line_q[k] <= dv_line_q[k-1];
  end

  // Stage 4: new multiplier and split products inverse mass * step.
  item_t              s4_d, s4_q;
  logic               s4_v_q;
  logic [55:0]        s4_phi_d [2];
  logic [55:0]        s4_phi_q [2];
  logic [55:0]        s4_plo_d [2];
  logic [55:0]        s4_plo_q [2];
  logic [31:0]        s4_g_d [3];
  logic [31:0]        s4_g_q [3];
  logic [33:0]        step_capped;
  logic signed [35:0] lam_sum;

  always_comb begin
    s4_d        = dv_line_q[DivLat-1];
    step_capped = (step_q > 64'(StepCap)) ? StepCap : step_q[33:0];
    lam_sum     = s4_d.dl_neg
                ? $signed({{4{s4_d.lam[31]}}, s4_d.lam}) - $signed({2'b00, step_capped})
                : $signed({{4{s4_d.lam[31]}}, s4_d.lam}) + $signed({2'b00, step_capped});
    if (s4_d.status == ST_APPLIED) s4_d.lam = sat32(lam_sum);
    s4_phi_d[0] = s4_d.inv_a * step_q[63:32];
    s4_plo_d[0] = s4_d.inv_a * step_q[31:0];
    s4_phi_d[1] = s4_d.inv_b * step_q[63:32];
    s4_plo_d[1] = s4_d.inv_b * step_q[31:0];
    for (int i = 0; i < 3; i++) s4_g_d[i] = dir_q[i][31:0];
  end

  // Stage 5: scaled step per particle, with a flag for overflow past 64 bits.
  item_t       s5_q;
  logic        s5_v_q;
  logic [47:0] s5_t_d [2];
  logic [47:0] s5_t_q [2];
  logic [1:0]  s5_tmax_d, s5_tmax_q;
  logic [31:0] s5_g_q [3];
  logic [87:0] mass_prod [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      mass_prod[p] = {s4_phi_q[p], 32'h0} + {32'h0, s4_plo_q[p]};
      s5_t_d[p]    = mass_prod[p][63:16];
      s5_tmax_d[p] = |mass_prod[p][87:64];
    end
  end

  // Stage 6: split products scaled step * direction.
  item_t       s6_q;
  logic        s6_v_q;
  logic [47:0] s6_mhi_d [2][3];
  logic [47:0] s6_mhi_q [2][3];
  logic [63:0] s6_mlo_d [2][3];
  logic [63:0] s6_mlo_q [2][3];
  logic [1:0]  s6_tmax_q;
  logic [2:0]  s6_gzero_d, s6_gzero_q;
  logic [2:0]  s6_gone_d, s6_gone_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_gzero_d[i] = (s5_g_q[i] == 32'd0);
      s6_gone_d[i]  = (s5_g_q[i] == 32'd1);
      for (int p = 0; p < 2; p++) begin
        s6_mhi_d[p][i] = s5_t_q[p][47:32] * s5_g_q[i];
        s6_mlo_d[p][i] = s5_t_q[p][31:0] * s5_g_q[i];
      end
    end
  end

  // Stage 7: axis corrections, capped.
  item_t       s7_q;
  logic        s7_v_q;
  logic [34:0] s7_corr_d [2][3];
  logic [34:0] s7_corr_q [2][3];
  logic [79:0] corr_sum [2][3];
  logic [49:0] corr_shr [2][3];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 3; i++) begin
        corr_sum[p][i] = {s6_mhi_q[p][i], 32'h0} + {16'h0000, s6_mlo_q[p][i]};
        corr_shr[p][i] = corr_sum[p][i][79:30];
        if (s6_tmax_q[p]) begin
          if (s6_gzero_q[i]) s7_corr_d[p][i] = '0;
          else if (s6_gone_q[i]) s7_corr_d[p][i] = CorrCap - 35'd1;
          else s7_corr_d[p][i] = CorrCap;
        end else if (corr_shr[p][i] > 50'(CorrCap)) begin
          s7_corr_d[p][i] = CorrCap;
        end else begin
          s7_corr_d[p][i] = corr_shr[p][i][34:0];
        end
      end
    end
  end

  // Stage 8: apply corrections to the unpinned particles.
  logic [2:0][31:0]   res_a, res_b;
  logic signed [35:0] sum_a [3];
  logic signed [35:0] sum_b [3];
  logic               neg_a, neg_b;

  always_comb begin
    res_a = s7_q.pos_a;
    res_b = s7_q.pos_b;
    for (int i = 0; i < 3; i++) begin
      neg_a = s7_q.dl_neg ^ s7_q.dneg[i];
      neg_b = !neg_a;
      sum_a[i] = neg_a
               ? $signed({{4{s7_q.pos_a[i][31]}}, s7_q.pos_a[i]}) - $signed({1'b0, s7_corr_q[0][i]})
               : $signed({{4{s7_q.pos_a[i][31]}}, s7_q.pos_a[i]}) + $signed({1'b0, s7_corr_q[0][i]});
      sum_b[i] = neg_b
               ? $signed({{4{s7_q.pos_b[i][31]}}, s7_q.pos_b[i]}) - $signed({1'b0, s7_corr_q[1][i]})
               : $signed({{4{s7_q.pos_b[i][31]}}, s7_q.pos_b[i]}) + $signed({1'b0, s7_corr_q[1][i]});
      if (s7_q.status == ST_APPLIED && !s7_q.pin_a) res_a[i] = sat32(sum_a[i]);
      if (s7_q.status == ST_APPLIED && !s7_q.pin_b) res_b[i] = sat32(sum_b[i]);
    end
  end

  // Valid bits of the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      s4_v_q <= &div_v;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
      done_o <= s7_v_q;
    end
  end

  // Data registers of the back end and the result word.
  always_ff @(posedge clk_i) begin
    s4_q       <= s4_d;
    s4_phi_q   <= s4_phi_d;
    s4_plo_q   <= s4_plo_d;
    s4_g_q     <= s4_g_d;
    s5_q       <= s4_q;
    s5_t_q     <= s5_t_d;
    s5_tmax_q  <= s5_tmax_d;
    s5_g_q     <= s4_g_q;
    s6_q       <= s5_q;
    s6_mhi_q   <= s6_mhi_d;
    s6_mlo_q   <= s6_mlo_d;
    s6_tmax_q  <= s5_tmax_q;
    s6_gzero_q <= s6_gzero_d;
    s6_gone_q  <= s6_gone_d;
    s7_q       <= s6_q;
    s7_corr_q  <= s7_corr_d;
    if (s7_v_q) begin
      new_first_x_o  <= res_a[0];
      new_first_y_o  <= res_a[1];
      new_first_z_o  <= res_a[2];
      new_second_x_o <= res_b[0];
      new_second_y_o <= res_b[1];
      new_second_z_o <= res_b[2];
      lambda_out_o   <= s7_q.lam;
      status_o       <= s7_q.status;
    end
  end

endmodule

[tb/xpbd_distance_constraint_checker.sv]
// Checker for the distance constraint block: predicts each result word and compares it.
`timescale 1ns / 100ps

module xpbd_distance_constraint_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [xdc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [xdc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [xdc_pkg::PosW-1:0]    first_x_i,
  input  logic [xdc_pkg::PosW-1:0]    first_y_i,
  input  logic [xdc_pkg::PosW-1:0]    first_z_i,
  input  logic [xdc_pkg::PosW-1:0]    second_x_i,
  input  logic [xdc_pkg::PosW-1:0]    second_y_i,
  input  logic [xdc_pkg::PosW-1:0]    second_z_i,
  input  logic [xdc_pkg::InvW-1:0]    first_inv_mass_i,
  input  logic [xdc_pkg::InvW-1:0]    second_inv_mass_i,
  input  logic                        first_pinned_i,
  input  logic                        second_pinned_i,
  input  logic [xdc_pkg::RestW-1:0]   rest_length_i,
  input  logic [xdc_pkg::LamW-1:0]    lambda_in_i,
  input  logic                        done_o,
  input  logic [xdc_pkg::PosW-1:0]    new_first_x_o,
  input  logic [xdc_pkg::PosW-1:0]    new_first_y_o,
  input  logic [xdc_pkg::PosW-1:0]    new_first_z_o,
  input  logic [xdc_pkg::PosW-1:0]    new_second_x_o,
  input  logic [xdc_pkg::PosW-1:0]    new_second_y_o,
  input  logic [xdc_pkg::PosW-1:0]    new_second_z_o,
  input  logic [xdc_pkg::LamW-1:0]    lambda_out_o,
  input  logic [1:0]                  status_o,
  output int                          err_count,
  output int                          outstanding
);
  import xdc_pkg::*;

  typedef struct {
    logic [2:0][31:0] first_pos;
    logic [2:0][31:0] second_pos;
    logic [31:0]      lambda;
    status_e          status;
  } projection_t;

  projection_t    projection_q[$];
  logic [31:0]    compliance_q;
  logic [31:0]    substep_dt_q;

  // Floor square root, one result bit per pass.
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Product shifted right, saturated at cap; a product past 64 bits saturates too.
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                  input int sh, input logic [63:0] cap);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != 0) return cap;
    p = p >> sh;
    return (p[63:0] > cap) ? cap : p[63:0];
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint mag_neg(input logic [63:0] m, input bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Alpha = compliance / dt^2 in Q16.16, saturating.
  function automatic logic [63:0] alpha_value();
    logic [63:0]  dt2;
    logic [127:0] r;
    dt2 = {32'd0, substep_dt_q} * {32'd0, substep_dt_q};
    r = {80'd0, compliance_q, 16'd0};
    if (r[63:0] >= dt2) return 64'hFFFF_FFFF;
    r = (r << 32) / {64'd0, dt2};
    return r[63:0];
  endfunction

  // Expected result of one constraint projection.
  function automatic projection_t project(input logic [2:0][31:0] pa, input logic [2:0][31:0] pb,
                                          input logic [23:0] inv_a, input logic [23:0] inv_b,
                                          input bit pin_a, input bit pin_b,
                                          input logic [30:0] rest, input logic [31:0] lam_raw);
    projection_t r;
    longint      d[3];
    logic [63:0] dm[3];
    logic [63:0] sum, sep_len, alpha, lam_mag, al_mag, nmag, den, q, qc, g, t, corr, m;
    longint      lam, c, num;
    bit          sh, dl_neg;
    r.first_pos = pa;
    r.second_pos = pb;
    r.lambda = lam_raw;
    lam = longint'(signed'(lam_raw));
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(signed'(pa[i])) - longint'(signed'(pb[i]));
      dm[i] = (d[i] < 0) ? -d[i] : d[i];
    end
    if (pin_a && pin_b) begin
      r.status = ST_BOTH_PINNED;
    end else if (dm[0] == 0 && dm[1] == 0 && dm[2] == 0) begin
      r.status = ST_ZERO_DIST;
    end else if (inv_a == 0 && inv_b == 0) begin
      r.status = ST_ZERO_WEIGHT;
    end else begin
      r.status = ST_APPLIED;
      // Halve every axis when one is too wide to square within 64 bits.
      sh = (dm[0] >= 64'h8000_0000) || (dm[1] >= 64'h8000_0000) || (dm[2] >= 64'h8000_0000);
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        m = dm[i] >> sh;
        sum = sum + m * m;
      end
      sep_len = floor_root(sum) << sh;
      c = longint'(sep_len) - longint'({33'd0, rest});
      alpha = alpha_value();
      lam_mag = (lam < 0) ? -lam : lam;
      al_mag = (alpha * lam_mag) >> 16;
      num = c + mag_neg(al_mag, lam < 0);
      nmag = (num < 0) ? -num : num;
      den = {40'd0, inv_a} + {40'd0, inv_b} + alpha;
      q = (nmag << 16) / den;
      dl_neg = num > 0;
      qc = (q > 64'd8589934592) ? 64'd8589934592 : q;
      r.lambda = clamp32(lam + mag_neg(qc, dl_neg));
      for (int i = 0; i < 3; i++) begin
        g = (dm[i] << 30) / sep_len;
        if (!pin_a) begin
          t = scaled_product({40'd0, inv_a}, q, 16, '1);
          corr = scaled_product(t, g, 30, 64'd17179869184);
          r.first_pos[i] = clamp32(longint'(signed'(pa[i])) +
                                   mag_neg(corr, dl_neg != (d[i] < 0)));
        end
        if (!pin_b) begin
          t = scaled_product({40'd0, inv_b}, q, 16, '1);
          corr = scaled_product(t, g, 30, 64'd17179869184);
          r.second_pos[i] = clamp32(longint'(signed'(pb[i])) +
                                    mag_neg(corr, dl_neg == (d[i] < 0)));
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Register mirror, expectation queue and comparison of each result word.
  always @(posedge clk_i or negedge rst_ni) begin
    projection_t want;
    if (!rst_ni) begin
      compliance_q <= ComplianceReset;
      substep_dt_q <= SubstepDtReset;
      projection_q.delete();
      outstanding <= 0;
      err_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_COMPLIANCE) compliance_q <= cfg_data_i;
        else if (cfg_index_i == REG_SUBSTEP_DT) substep_dt_q <= cfg_data_i;
      end
      if (start && !busy) begin
        projection_q.insert(projection_q.size(),
                            project({first_z_i, first_y_i, first_x_i},
                                    {second_z_i, second_y_i, second_x_i},
                                    first_inv_mass_i, second_inv_mass_i,
                                    first_pinned_i, second_pinned_i,
                                    rest_length_i, lambda_in_i));
      end
      if (done_o) begin
        if (projection_q.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          err_count++;
        end else begin
          want = projection_q.pop_front();
          if (new_first_x_o !== want.first_pos[0])
            report_mismatch("new_first_x", new_first_x_o, want.first_pos[0]);
          if (new_first_y_o !== want.first_pos[1])
            report_mismatch("new_first_y", new_first_y_o, want.first_pos[1]);
          if (new_first_z_o !== want.first_pos[2])
            report_mismatch("new_first_z", new_first_z_o, want.first_pos[2]);
          if (new_second_x_o !== want.second_pos[0])
            report_mismatch("new_second_x", new_second_x_o, want.second_pos[0]);
          if (new_second_y_o !== want.second_pos[1])
            report_mismatch("new_second_y", new_second_y_o, want.second_pos[1]);
          if (new_second_z_o !== want.second_pos[2])
            report_mismatch("new_second_z", new_second_z_o, want.second_pos[2]);
          if (lambda_out_o !== want.lambda)
            report_mismatch("lambda_out", lambda_out_o, want.lambda);
          if (status_o !== want.status)
            report_mismatch("status", {30'd0, status_o}, {30'd0, want.status});
        end
      end
      outstanding <= projection_q.size();
    end
  end

endmodule

[tb/xpbd_distance_constraint_tb.sv]
// Testbench top for the distance constraint block: stimulus, register phases and verdict.
`timescale 1ns / 100ps

module xpbd_distance_constraint_tb;
  import xdc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 120;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic [PosW-1:0]    first_x_i, first_y_i, first_z_i;
  logic [PosW-1:0]    second_x_i, second_y_i, second_z_i;
  logic [InvW-1:0]    first_inv_mass_i, second_inv_mass_i;
  logic               first_pinned_i, second_pinned_i;
  logic [RestW-1:0]   rest_length_i;
  logic [LamW-1:0]    lambda_in_i;
  logic               done_o;
  logic [PosW-1:0]    new_first_x_o, new_first_y_o, new_first_z_o;
  logic [PosW-1:0]    new_second_x_o, new_second_y_o, new_second_z_o;
  logic [LamW-1:0]    lambda_out_o;
  logic [1:0]         status_o;
  int                 err_count;
  int                 outstanding;
  int                 cycle_count;
  int                 burst_left;

  xpbd_distance_constraint uut (.*);
  xpbd_distance_constraint_checker checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("xpbd_distance_constraint_tb: errors");
      $finish;
    end
  end

  // Drive one constraint word and hold it until the block takes it.
  task automatic send_word(input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                           input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
                           input logic [23:0] wa, input logic [23:0] wb, input bit fa,
                           input bit fb, input logic [30:0] rest, input logic [31:0] lam);
    first_x_i = ax; first_y_i = ay; first_z_i = az;
    second_x_i = bx; second_y_i = by; second_z_i = bz;
    first_inv_mass_i = wa; second_inv_mass_i = wb;
    first_pinned_i = fa; second_pinned_i = fb;
    rest_length_i = rest; lambda_in_i = lam;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    // Sender bursts: after each burst, drop start for a random gap.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Wait for every result, then write one register.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One random constraint word; most are near-neighbor particles with sane masses.
  task automatic random_word();
    logic [31:0] ax, ay, az, bx, by, bz, lam;
    logic [23:0] wa, wb;
    logic [30:0] rest;
    int          kind;
    kind = $urandom_range(0, 9);
    ax = $urandom; ay = $urandom; az = $urandom;
    if (kind < 6) begin
      ax = $signed(ax) >>> $urandom_range(4, 14);
      ay = $signed(ay) >>> $urandom_range(4, 14);
      az = $signed(az) >>> $urandom_range(4, 14);
      bx = ax + ($signed($urandom) >>> $urandom_range(8, 20));
      by = ay + ($signed($urandom) >>> $urandom_range(8, 20));
      bz = az + ($signed($urandom) >>> $urandom_range(8, 20));
      rest = 31'($urandom >> $urandom_range(11, 20));
      wa = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 24'h3_0000));
      wb = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 24'h3_0000));
      lam = $signed($urandom) >>> $urandom_range(0, 20);
    end else begin
      bx = $urandom; by = $urandom; bz = $urandom;
      rest = 31'($urandom);
      wa = 24'($urandom); wb = 24'($urandom);
      lam = $urandom;
    end
    if (kind == 9) begin
      bx = ax; by = ay; bz = az;
    end
    if ($urandom_range(0, 15) == 0) begin
      wa = '0;
      wb = '0;
    end
    send_word(ax, ay, az, bx, by, bz, wa, wb, $urandom_range(0, 5) == 0,
              $urandom_range(0, 5) == 0, rest, lam);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_COMPLIANCE;
    cfg_data_i = '0;
    burst_left = 0;
    cycle_count = 0;
    {first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i} = '0;
    {first_inv_mass_i, second_inv_mass_i, first_pinned_i, second_pinned_i} = '0;
    rest_length_i = '0;
    lambda_in_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // Directed words under the reset register values.
    send_word(32'h0001_0000, 0, 0, 0, 0, 0, 24'h1_0000, 24'h1_0000, 0, 0, 31'h0, 0);
    send_word(32'h0002_0000, 0, 0, 0, 0, 0, 24'h1_0000, 24'h1_0000, 0, 0, 31'h1_0000, 0);
    send_word(1, 2, 3, 4, 5, 6, 24'h1_0000, 24'h1_0000, 1, 1, 31'h1_0000, 32'h1234);
    send_word(7, 7, 7, 7, 7, 7, 24'h1_0000, 24'h1_0000, 0, 0, 31'h1_0000, 32'h5678);
    send_word(1, 2, 3, 4, 5, 6, 0, 0, 0, 0, 31'h1_0000, 32'hFFFF_0000);
    send_word(32'h0003_0000, 0, 0, 0, 0, 0, 24'h1_0000, 24'h2_0000, 1, 0, 31'h1_0000, 0);
    send_word(0, 32'h0003_0000, 0, 0, 0, 0, 24'h2_0000, 24'h1_0000, 0, 1, 31'h1_0000, 0);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 0, 0, 31'h0, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
              24'hFF_FFFF, 24'h00_0001, 0, 0, 31'h7FFF_FFFF, 32'h8000_0000);
    send_word(0, 0, 1, 0, 0, 0, 24'h00_0001, 0, 0, 0, 31'h7FFF_FFFF, 32'h8000_0000);
    send_word(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 24'hFF_FFFF, 24'hFF_FFFF,
              0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF);

    // Register phases: the reset step with a small compliance, the extremes and random settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_COMPLIANCE, 32'h0000_0100);
          write_reg(REG_SUBSTEP_DT, SubstepDtReset);
        end
        1: begin
          write_reg(REG_COMPLIANCE, 32'hFFFF_FFFF);
          write_reg(REG_SUBSTEP_DT, 32'd1);
        end
        2: begin
          write_reg(REG_COMPLIANCE, 32'd1);
          write_reg(REG_SUBSTEP_DT, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(REG_COMPLIANCE, 32'd0);
          write_reg(REG_SUBSTEP_DT, 32'h0001_0000);
        end
        default: begin
          write_reg(REG_COMPLIANCE, $urandom >> $urandom_range(0, 31));
          write_reg(REG_SUBSTEP_DT, ($urandom >> $urandom_range(0, 31)) | 32'd1);
        end
      endcase
      send_word(32'h0004_0000, 32'h0001_0000, 0, 0, 0, 0, 24'h1_0000, 24'h1_0000, 0, 0,
                31'h2_0000, 32'h0000_8000);
      for (int n = 0; n < 200; n++) random_word();
    end

    start = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_count == 0) begin
      $display("xpbd_distance_constraint_tb: clean");
    end else begin
      $display("xpbd_distance_constraint_tb: errors");
    end
    $finish;
  end

endmodule
